>>> sv/pcfd_pkg.sv
// Shared types, constants and helper functions for the filtered-derivative PID block.
// Used by pcfd_div and pid_controller_filtered_derivative; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pcfd_pkg;

  // Fixed-point format and derivative source.
  localparam int FracBits = 16;
  localparam bit DerivOnMeas = 1'b1;

  // Width of the wide accumulation path (sums of 48-bit terms).
  localparam int WideW = 52;

  // Shift that takes cutoff*dt*2pi from Q(FracBits+29) to Q(FracBits).
  localparam int XShift = FracBits + 13;

  // 2*pi in Q3.29.
  localparam logic [32:0] TwoPiQ29 = 33'h0C90FDAA2;

  localparam logic signed [WideW-1:0] I32Max = {{(WideW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [WideW-1:0] I32Min = {{(WideW-31){1'b1}}, {31{1'b0}}};

  // Configuration register indexes.
  typedef enum logic [3:0] {
    REG_KP     = 4'd0,
    REG_KI     = 4'd1,
    REG_KD     = 4'd2,
    REG_CUTOFF = 4'd3,
    REG_INT_LO = 4'd4,
    REG_INT_HI = 4'd5,
    REG_OUT_LO = 4'd6,
    REG_OUT_HI = 4'd7
  } reg_idx_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_OVF    = 2'd2
  } status_e;

  // Saturated value with its overflow flag.
  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  // Request to the shared divider: quotient of (num * 2^32) / den, num < den.
  typedef struct packed {
    logic        start;
    logic [32:0] num;
    logic [32:0] den;
  } div_req_t;

  // Divider status back to the sequencer.
  typedef struct packed {
    logic        done;
    logic        busy;
    logic [31:0] quot;
  } div_rsp_t;

  // Saturate a wide signed value to 32 bits.
  function automatic sat_t sat32(input logic signed [WideW-1:0] x);
    sat_t r;
    r.val = x[31:0];
    r.ovf = 1'b0;
    if (x > I32Max) begin
      r.val = 32'h7FFF_FFFF;
      r.ovf = 1'b1;
    end else if (x < I32Min) begin
      r.val = 32'h8000_0000;
      r.ovf = 1'b1;
    end
    return r;
  endfunction

  // Clamp a wide signed value into [lo, hi].
  function automatic logic [31:0] clamp32(input logic signed [WideW-1:0] x,
                                          input logic signed [31:0] lo,
                                          input logic signed [31:0] hi);
    logic [31:0] r;
    r = x[31:0];
    if (x < WideW'(lo)) begin
      r = lo;
    end else if (x > WideW'(hi)) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/pcfd_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 32 bits per request.
// Depends on pcfd_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module pcfd_div (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire pcfd_pkg::div_req_t  req_i,
  output pcfd_pkg::div_rsp_t       rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] rem_q, rem_d;
  logic [32:0] den_q, den_d;
  logic [31:0] quot_q, quot_d;

  logic [33:0] shifted;
  logic [33:0] trial;
  logic        fits;

  // One restoring step: shift the remainder and try to subtract the divisor.
  assign shifted = {rem_q, 1'b0};
  assign trial   = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d  = fits ? trial[32:0] : shifted[32:0];
      quot_d = {quot_q[30:0], fits};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

>>> sv/pid_controller_filtered_derivative.sv
// A reset or rejected beat goes from S_ERR through S_OUT to the output register. An update
// runs S_P to S_INT; once a previous sample exists it adds the slope division unless the
// slope saturates, then S_SIG and, when the cutoff is nonzero, the filter; then S_D to S_OUT.
// Only one beat is taken at a time, in S_IDLE; the shared multiplier and bit-serial divider
// serve the states in turn. A result waits in the output register while the next beat runs.
// Reset clears controller state and loads the register defaults at once; no clearing pass.
// Depends on pcfd_pkg and pcfd_div.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_filtered_derivative (
  input  wire          clk_i,
  input  wire          rst_ni,
  // Configuration write port.
  input  wire          cfg_we_i,
  input  wire  [3:0]   cfg_addr_i,
  input  wire  [31:0]  cfg_data_i,
  // Input beats.
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // setpoint, measurement, velocity_ff, accel_ff, extra_ff, time_step, integral seed
  input  wire  [223:0] s_axis_tdata,
  // func
  input  wire  [0:0]   s_axis_tuser,
  // Result beats.
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // control_output, proportional_term, integral_term, derivative_term,
  // feedforward_sum, raw_output
  output logic [191:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);

  localparam int W = pcfd_pkg::WideW;

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_P, S_EDT, S_INC, S_I, S_INT, S_DIVW, S_SIG, S_HI, S_LO,
    S_X, S_DIVA, S_MA, S_FILT, S_D, S_SUM, S_RAW, S_AW, S_FIN, S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic signed [31:0] kp_q, ki_q, kd_q;
  logic        [31:0] cut_q;
  logic signed [31:0] ilo_q, ihi_q, olo_q, ohi_q;

  // Latched input beat.
  logic               func_q;
  logic signed [31:0] sp_q, meas_q, vff_q, aff_q, eff_q, init_q;
  logic        [31:0] dt_q;

  // Controller state.
  logic signed [31:0] acc_q, lerr_q, lmeas_q, fs_q;
  logic               hp_q;

  // Working registers.
  logic signed [65:0] prod_q;
  logic signed [31:0] err_q, integ_q, sig_q, filt_q;
  logic signed [47:0] p_q, d_q;
  logic signed [32:0] edt_q;
  logic signed [33:0] ff_q;
  logic signed [W-1:0] raw_q;
  logic        [32:0] qdt_q;
  logic               dneg_q, mneg_q, ovf_q;
  logic        [31:0] plo_q, md_q;
  logic        [63:0] thi_q;

  // Finished result awaiting the output register.
  logic [191:0] res_data_q;
  logic [1:0]   res_stat_q;

  // Output register.
  logic         out_valid_q;
  logic [191:0] out_data_q;
  logic [1:0]   out_stat_q;

  pcfd_pkg::div_req_t div_req;
  pcfd_pkg::div_rsp_t div_rsp;

  pcfd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Shared multiplier operand selection.
  logic signed [32:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_P:   begin mul_a = 33'(kp_q);              mul_b = 33'(err_q); end
      S_EDT: begin mul_a = 33'(err_q);             mul_b = {1'b0, dt_q}; end
      S_I:   begin mul_a = 33'(ki_q);              mul_b = edt_q; end
      S_SIG: begin mul_a = {1'b0, cut_q};          mul_b = {1'b0, dt_q}; end
      S_HI:  begin mul_a = {1'b0, prod_q[63:32]};  mul_b = pcfd_pkg::TwoPiQ29; end
      S_LO:  begin mul_a = {1'b0, plo_q};          mul_b = pcfd_pkg::TwoPiQ29; end
      S_MA:  begin mul_a = {1'b0, md_q};           mul_b = {1'b0, div_rsp.quot}; end
      S_D:   begin mul_a = 33'(kd_q);              mul_b = 33'(filt_q); end
      default: ;
    endcase
  end

  // Round-half-up rescales of the registered product.
  logic signed [65:0] rnd_f, rnd_32;
  assign rnd_f  = (prod_q + (66'sd1 <<< (pcfd_pkg::FracBits - 1))) >>> pcfd_pkg::FracBits;
  assign rnd_32 = (prod_q + (66'sd1 <<< 31)) >>> 32;

  // Configuration checks and the reset-beat results.
  logic cfg_bad;
  assign cfg_bad = (ilo_q > ihi_q) || (olo_q >= ohi_q);

  logic signed [32:0] err_wide;
  pcfd_pkg::sat_t     err_sat;
  logic        [31:0] integ_rst, outc_rst;
  assign err_wide  = 33'(sp_q) - 33'(meas_q);
  assign err_sat   = pcfd_pkg::sat32(W'(err_wide));
  assign integ_rst = pcfd_pkg::clamp32(W'(init_q), ilo_q, ihi_q);
  assign outc_rst  = pcfd_pkg::clamp32(W'($signed(integ_rst)), olo_q, ohi_q);

  // Integral update and derivative difference.
  logic signed [W-1:0] int_sum;
  logic        [31:0]  integ_new;
  logic signed [32:0]  diff;
  logic        [32:0]  diff_mag;
  logic                diff_big;
  assign int_sum   = W'(acc_q) + W'($signed(rnd_f[47:0]));
  assign integ_new = pcfd_pkg::clamp32(int_sum, ilo_q, ihi_q);
  assign diff      = pcfd_pkg::DerivOnMeas ? (33'(lmeas_q) - 33'(meas_q))
                                           : (33'(err_q) - 33'(lerr_q));
  assign diff_mag  = diff[32] ? 33'(-diff) : 33'(diff);
  assign diff_big  = (diff_mag >= 33'h0_8000_0000) || (diff_mag >= {1'b0, dt_q});

  // Signed slope from the quotient magnitude.
  logic signed [33:0] slope;
  pcfd_pkg::sat_t     slope_sat;
  assign slope     = dneg_q ? -$signed({1'b0, qdt_q}) : $signed({1'b0, qdt_q});
  assign slope_sat = pcfd_pkg::sat32(W'(slope));

  // Filter argument: cutoff*dt*2pi in Q(FracBits), capped to 32 bits.
  logic [65:0] targ, xs;
  logic [31:0] xarg;
  logic [32:0] aden;
  assign targ = {2'b0, thi_q} + {32'b0, prod_q[65:32]};
  assign xs   = targ >> pcfd_pkg::XShift;
  assign xarg = (|xs[65:32]) ? 32'hFFFF_FFFF : xs[31:0];
  assign aden = (33'd1 << pcfd_pkg::FracBits) + {1'b0, xarg};

  // Filter step difference.
  logic signed [32:0] fdiff;
  assign fdiff = 33'(sig_q) - 33'(fs_q);

  // Filter output: move toward the new slope by the rounded fraction.
  logic signed [32:0] fstep;
  assign fstep = mneg_q ? (33'(fs_q) - $signed({1'b0, rnd_32[31:0]}))
                        : (33'(fs_q) + $signed({1'b0, rnd_32[31:0]}));

  // Output sums, with and without the integral update.
  logic signed [W-1:0] raw_aw;
  logic                windup;
  assign raw_aw = W'(p_q) + W'(acc_q) + W'(d_q) + W'(ff_q);
  assign windup = (raw_q > W'(ohi_q) && err_q > 0) || (raw_q < W'(olo_q) && err_q < 0);

  // Final saturation.
  pcfd_pkg::sat_t pt_sat, dt_sat, ff_sat, rs_sat;
  logic           ovf_all;
  logic [31:0]    outc;
  assign pt_sat  = pcfd_pkg::sat32(W'(p_q));
  assign dt_sat  = pcfd_pkg::sat32(W'(d_q));
  assign ff_sat  = pcfd_pkg::sat32(W'(ff_q));
  assign rs_sat  = pcfd_pkg::sat32(raw_q);
  assign ovf_all = ovf_q | pt_sat.ovf | dt_sat.ovf | ff_sat.ovf | rs_sat.ovf;
  assign outc    = pcfd_pkg::clamp32(W'($signed(rs_sat.val)), olo_q, ohi_q);

  // Divider requests: slope division and filter factor division.
  always_comb begin
    div_req = '0;
    if (state_q == S_INT && hp_q && !diff_big) begin
      div_req.start = 1'b1;
      div_req.num   = diff_mag;
      div_req.den   = {1'b0, dt_q};
    end else if (state_q == S_X) begin
      div_req.start = 1'b1;
      div_req.num   = {1'b0, xarg};
      div_req.den   = aden;
    end
  end

  logic in_beat;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // The finished result moves into the output register when that is free or draining.
  logic out_load;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  // Sequencer with its registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      cut_q       <= '0;
      ilo_q       <= 32'sh8000_0000;
      ihi_q       <= 32'sh7FFF_FFFF;
      olo_q       <= 32'sh8000_0000;
      ohi_q       <= 32'sh7FFF_FFFF;
      acc_q       <= '0;
      lerr_q      <= '0;
      lmeas_q     <= '0;
      fs_q        <= '0;
      hp_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // The user must write registers only while idle; the block itself does not enforce this.
      if (cfg_we_i) begin
        case (cfg_addr_i)
          pcfd_pkg::REG_KP:     kp_q  <= cfg_data_i;
          pcfd_pkg::REG_KI:     ki_q  <= cfg_data_i;
          pcfd_pkg::REG_KD:     kd_q  <= cfg_data_i;
          pcfd_pkg::REG_CUTOFF: cut_q <= cfg_data_i;
          pcfd_pkg::REG_INT_LO: ilo_q <= cfg_data_i;
          pcfd_pkg::REG_INT_HI: ihi_q <= cfg_data_i;
          pcfd_pkg::REG_OUT_LO: olo_q <= cfg_data_i;
          pcfd_pkg::REG_OUT_HI: ohi_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Output register handshake.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            state_q <= S_ERR;
          end
        end
        S_ERR: begin
          err_q <= err_sat.val;
          ovf_q <= err_sat.ovf;
          if (cfg_bad || (!func_q && dt_q == '0)) begin
            res_data_q <= '0;
            res_stat_q <= pcfd_pkg::STAT_REJECT;
            state_q    <= S_OUT;
          end else if (func_q) begin
            // Reset beat seeds the integral and the previous sample.
            acc_q      <= integ_rst;
            lerr_q     <= '0;
            lmeas_q    <= meas_q;
            fs_q       <= '0;
            hp_q       <= 1'b1;
            res_data_q <= {integ_rst, 32'd0, 32'd0, integ_rst, 32'd0, outc_rst};
            res_stat_q <= pcfd_pkg::STAT_OK;
            state_q    <= S_OUT;
          end else begin
            state_q <= S_P;
          end
        end
        S_P:   state_q <= S_EDT;
        S_EDT: begin
          p_q     <= rnd_f[47:0];
          state_q <= S_INC;
        end
        S_INC: begin
          edt_q   <= rnd_32[32:0];
          state_q <= S_I;
        end
        S_I:   state_q <= S_INT;
        S_INT: begin
          integ_q <= integ_new;
          dneg_q  <= diff[32];
          if (!hp_q) begin
            filt_q  <= '0;
            state_q <= S_D;
          end else if (diff_big) begin
            qdt_q   <= 33'h1_0000_0000;
            state_q <= S_SIG;
          end else begin
            state_q <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            qdt_q   <= {1'b0, div_rsp.quot};
            state_q <= S_SIG;
          end
        end
        S_SIG: begin
          sig_q <= slope_sat.val;
          ovf_q <= ovf_q | slope_sat.ovf;
          if (cut_q == '0) begin
            filt_q  <= slope_sat.val;
            state_q <= S_D;
          end else begin
            state_q <= S_HI;
          end
        end
        S_HI: begin
          plo_q   <= prod_q[31:0];
          state_q <= S_LO;
        end
        S_LO: begin
          thi_q   <= prod_q[63:0];
          state_q <= S_X;
        end
        S_X: begin
          mneg_q  <= fdiff[32];
          md_q    <= fdiff[32] ? 32'(-fdiff) : 32'(fdiff);
          state_q <= S_DIVA;
        end
        S_DIVA: begin
          if (div_rsp.done) begin
            state_q <= S_MA;
          end
        end
        S_MA:  state_q <= S_FILT;
        S_FILT: begin
          filt_q  <= fstep[31:0];
          state_q <= S_D;
        end
        S_D:   state_q <= S_SUM;
        S_SUM: begin
          d_q     <= rnd_f[47:0];
          ff_q    <= 34'(vff_q) + 34'(aff_q) + 34'(eff_q);
          state_q <= S_RAW;
        end
        S_RAW: begin
          raw_q   <= W'(p_q) + W'(integ_q) + W'(d_q) + W'(ff_q);
          state_q <= S_AW;
        end
        S_AW: begin
          // Hold the integral when saturation pushes the same way as the error.
          if (windup) begin
            integ_q <= acc_q;
            raw_q   <= raw_aw;
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!ovf_all) begin
            acc_q   <= integ_q;
            lerr_q  <= err_q;
            lmeas_q <= meas_q;
            fs_q    <= filt_q;
            hp_q    <= 1'b1;
          end
          res_data_q <= {rs_sat.val, ff_sat.val, dt_sat.val, integ_q, pt_sat.val, outc};
          res_stat_q <= ovf_all ? pcfd_pkg::STAT_OVF : pcfd_pkg::STAT_OK;
          state_q    <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_beat) begin
      func_q <= s_axis_tuser[0];
      sp_q   <= s_axis_tdata[31:0];
      meas_q <= s_axis_tdata[63:32];
      vff_q  <= s_axis_tdata[95:64];
      aff_q  <= s_axis_tdata[127:96];
      eff_q  <= s_axis_tdata[159:128];
      dt_q   <= s_axis_tdata[191:160];
      init_q <= s_axis_tdata[223:192];
    end
    if (out_load) begin
      out_data_q <= res_data_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

  // The divider is never running while a new beat can be taken.
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_rsp.busy)
    else $error("divider busy while idle");

  // A waited-for division must be running or just finished.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVW || state_q == S_DIVA) |-> (div_rsp.busy || div_rsp.done))
    else $error("sequencer waits on an idle divider");

  // Status codes carried out are always defined ones.
  a_stat_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == pcfd_pkg::STAT_OK ||
                       m_axis_tuser == pcfd_pkg::STAT_REJECT ||
                       m_axis_tuser == pcfd_pkg::STAT_OVF))
    else $error("undefined status on result beat");

  // An accepted beat blocks further input on the next cycle.
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat accepted while busy");

endmodule

`default_nettype wire
